// ===== hdl/ulfr_pkg.sv =====
// Shared constants, codes and types of the UART line frame receiver.
package ulfr_pkg;

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int PULSE_W   = 20;
  localparam int EVENT_W   = 3;
  localparam int OFFS_W    = 2;
  localparam int IDLE_W    = 16;
  localparam int PCOUNT_W  = 18;
  localparam int CRC_W     = 16;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PULSE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  // Result events.
  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_FRAME   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CRC_BAD = 3'd2;
  localparam logic [EVENT_W-1:0] EV_FLUSH   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_READ    = 3'd4;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_LINE_MODE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CRC_ENABLE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_TICKS   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_LIMIT = 2'd3;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;

  localparam logic [8:0] MIN_WITH_CRC = 9'd4;
  localparam logic [8:0] MIN_PLAIN    = 9'd2;

  // Division by five of a 20-bit value: multiply by ceil(2^22/5), keep bits above 22.
  localparam logic [PULSE_W-1:0] RECIP_5    = 20'd838861;
  localparam int                 DIV5_SHIFT = 22;
  localparam int                 PROD_W     = 2 * PULSE_W;

  typedef struct packed {
    logic              init;
    logic              step;
    logic [BYTE_W-1:0] data;
  } crc_ctrl_t;

endpackage

// ===== hdl/ulfr_in_if.sv =====
// Input item channel of the UART line frame receiver.
interface ulfr_in_if;
  logic                          valid;
  logic                          ready;
  logic [ulfr_pkg::CMD_W-1:0]    command;
  logic [ulfr_pkg::BYTE_W-1:0]   rx_byte;
  logic [ulfr_pkg::PULSE_W-1:0]  pulse_us;
  logic [ulfr_pkg::BYTE_W-1:0]   read_index;

  modport source (output valid, command, rx_byte, pulse_us, read_index, input ready);
  modport sink   (input valid, command, rx_byte, pulse_us, read_index, output ready);
endinterface

// ===== hdl/ulfr_out_if.sv =====
// Result item channel of the UART line frame receiver.
interface ulfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [ulfr_pkg::EVENT_W-1:0]  event_res;
  logic [ulfr_pkg::BYTE_W-1:0]   frame_length;
  logic [ulfr_pkg::OFFS_W-1:0]   payload_offset;
  logic [ulfr_pkg::BYTE_W-1:0]   read_data;
  logic                          tx_low;

  modport source (output valid, event_res, frame_length, payload_offset, read_data, tx_low,
                  input ready);
  modport sink   (input valid, event_res, frame_length, payload_offset, read_data, tx_low,
                  output ready);
endinterface

// ===== hdl/ulfr_cfg_if.sv =====
// Configuration write channel of the UART line frame receiver.
interface ulfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ulfr_pkg::REG_IDX_W-1:0]  index;
  logic [ulfr_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ulfr_store.sv =====
// Frame store: one write port and one registered read port.
module ulfr_store #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [ulfr_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [ulfr_pkg::BYTE_W-1:0] rd_data
);
  import ulfr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/ulfr_crc.sv =====
// CRC16-CCITT accumulator that folds in one byte per cycle while step is set.
module ulfr_crc (
  input  logic                       clk,
  input  ulfr_pkg::crc_ctrl_t        ctrl,
  output logic [ulfr_pkg::CRC_W-1:0] crc
);
  import ulfr_pkg::*;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    c = c_in ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      crc <= CRC_INIT;
    end else if (ctrl.step) begin
      crc <= crc_byte(crc, ctrl.data);
    end
  end

endmodule

// ===== hdl/uart_line_frame_receiver_core.sv =====
// UART line frame receiver: command sequencer, frame store and CRC walk.
// A byte or tick result goes to S_OUT, a pulse or read result through S_PULSE or S_READ,
// and a CRC frame end through S_C0, S_C1, S_C2, S_CWALK per payload byte and S_CCHK.
// No item is taken until the last result has left S_OUT; a CRC frame end holds the input
// for the walk of the stored payload, one byte per cycle through the single store read port.
// Reset: rst (synchronous) restores the control state and configuration registers; the frame store is not cleared.
module uart_line_frame_receiver_core #(
  parameter int STORE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  ulfr_in_if.sink    in_ch,
  ulfr_out_if.source out_ch,
  ulfr_cfg_if.sink   cfg_ch
);
  import ulfr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);

  // Every store index is taken modulo the store depth. All indexes used here stay below
  // 256, so a constant map, worked out at elaboration, replaces the modulo.
  typedef logic [AW-1:0] idx_map_t [256];

  function automatic idx_map_t build_idx_map();
    idx_map_t m;
    for (int k = 0; k < 256; k++) begin
      m[k] = AW'(k % STORE_DEPTH);
    end
    return m;
  endfunction

  localparam idx_map_t IDX_MAP = build_idx_map();

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PULSE = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_C0    = 4'd3;
  localparam logic [3:0] S_C1    = 4'd4;
  localparam logic [3:0] S_C2    = 4'd5;
  localparam logic [3:0] S_CWALK = 4'd6;
  localparam logic [3:0] S_CCHK  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // Configuration registers.
  logic              line_mode;
  logic              crc_enable;
  logic [IDLE_W-1:0] idle_ticks;
  logic [BYTE_W-1:0] buffer_limit;

  // Control state.
  logic [3:0]          state, state_next;
  logic [BYTE_W-1:0]   fill, fill_next;
  logic [IDLE_W-1:0]   idle_cd, idle_cd_next;
  logic [PCOUNT_W-1:0] pulse_cd, pulse_cd_next;
  logic                out_valid, out_valid_next;

  // Working registers of one transaction.
  logic [BYTE_W-1:0]   last_byte, last_byte_next;
  logic [BYTE_W-1:0]   crc_len, crc_len_next;
  logic [BYTE_W-1:0]   walk_idx, walk_idx_next;
  logic [CRC_W-1:0]    got, got_next;
  logic [PROD_W-1:0]   prod, prod_next;

  // Pending result.
  logic [EVENT_W-1:0]  res_event, res_event_next;
  logic [BYTE_W-1:0]   res_len, res_len_next;
  logic [OFFS_W-1:0]   res_offs, res_offs_next;
  logic [BYTE_W-1:0]   res_rdata, res_rdata_next;

  // Store and CRC unit connections.
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] rd_data;
  crc_ctrl_t         crc_ctrl;
  logic [CRC_W-1:0]  crc_val;

  logic              accept;
  logic              out_load;
  logic              end_hit;
  logic [8:0]        complete;
  logic [BYTE_W-1:0] fill_adv;
  logic [BYTE_W-1:0] tick_fill;

  ulfr_store #(.DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_ch.rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ulfr_crc u_crc (
    .clk  (clk),
    .ctrl (crc_ctrl),
    .crc  (crc_val)
  );

  assign in_ch.ready  = (state == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;

  // The fill advances by one below the limit and otherwise wraps to zero.
  assign fill_adv = (fill < buffer_limit) ? fill + 8'd1 : 8'd0;

  // Whenever the fill is nonzero, the last byte written sits just below the fill index,
  // so a copy of that byte decides the CR LF frame end without a store read.
  assign end_hit  = (fill != 8'd0) && (last_byte == CH_CR) && (in_ch.rx_byte == CH_LF);
  assign complete = {1'b0, fill} + 9'd1;

  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    idle_cd_next   = idle_cd;
    pulse_cd_next  = pulse_cd;
    last_byte_next = last_byte;
    crc_len_next   = crc_len;
    walk_idx_next  = walk_idx;
    got_next       = got;
    prod_next      = prod;
    res_event_next = res_event;
    res_len_next   = res_len;
    res_offs_next  = res_offs;
    res_rdata_next = res_rdata;
    wr_en          = 1'b0;
    wr_addr        = IDX_MAP[fill];
    rd_en          = 1'b0;
    rd_addr        = IDX_MAP[in_ch.read_index];
    crc_ctrl       = '{init: 1'b0, step: 1'b0, data: rd_data};
    tick_fill      = fill;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_event_next = EV_NONE;
          res_len_next   = 8'd0;
          res_offs_next  = 2'd0;
          res_rdata_next = 8'd0;
          state_next     = S_OUT;
          case (in_ch.command)
            CMD_BYTE: begin
              wr_en          = 1'b1;
              last_byte_next = in_ch.rx_byte;
              if (line_mode) begin
                fill_next = end_hit ? 8'd0 : fill_adv;
                if (crc_enable) begin
                  if (end_hit && complete >= MIN_WITH_CRC) begin
                    crc_len_next = 8'(complete - MIN_WITH_CRC);
                    state_next   = S_C0;
                  end
                end else if (end_hit && complete >= MIN_PLAIN) begin
                  res_event_next = EV_FRAME;
                  res_len_next   = 8'(complete - MIN_PLAIN);
                end
              end else begin
                idle_cd_next = idle_ticks;
                fill_next    = fill_adv;
              end
            end
            CMD_TICK: begin
              if (!line_mode && fill != 8'd0) begin
                if (idle_cd != '0) begin
                  idle_cd_next = idle_cd - 1'b1;
                end else begin
                  res_event_next = EV_FLUSH;
                  res_len_next   = fill;
                  tick_fill      = 8'd0;
                end
              end
              if (pulse_cd != '0) begin
                pulse_cd_next = pulse_cd - 1'b1;
                if (pulse_cd == PCOUNT_W'(1)) begin
                  tick_fill = 8'd0;
                end
              end
              fill_next = tick_fill;
            end
            CMD_PULSE: begin
              prod_next  = PROD_W'(in_ch.pulse_us) * PROD_W'(RECIP_5);
              state_next = S_PULSE;
            end
            CMD_READ: begin
              rd_en      = 1'b1;
              state_next = S_READ;
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_PULSE: begin
        // The quotient fits the countdown, so adding one never wraps.
        pulse_cd_next = prod[DIV5_SHIFT +: PCOUNT_W] + PCOUNT_W'(1);
        state_next    = S_OUT;
      end
      S_READ: begin
        res_event_next = EV_READ;
        res_rdata_next = rd_data;
        state_next     = S_OUT;
      end
      S_C0: begin
        rd_en      = 1'b1;
        rd_addr    = IDX_MAP[8'd0];
        state_next = S_C1;
      end
      S_C1: begin
        got_next[15:8] = rd_data;
        rd_en          = 1'b1;
        rd_addr        = IDX_MAP[8'd1];
        state_next     = S_C2;
      end
      S_C2: begin
        got_next[7:0] = rd_data;
        crc_ctrl.init = 1'b1;
        walk_idx_next = 8'd0;
        if (crc_len == 8'd0) begin
          state_next = S_CCHK;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = IDX_MAP[8'd2];
          state_next = S_CWALK;
        end
      end
      S_CWALK: begin
        // The payload starts right after the two CRC bytes.
        crc_ctrl.step = 1'b1;
        if (walk_idx + 8'd1 == crc_len) begin
          state_next = S_CCHK;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = IDX_MAP[8'(walk_idx + 8'd3)];
          walk_idx_next = walk_idx + 8'd1;
        end
      end
      S_CCHK: begin
        if (crc_val == got) begin
          res_event_next = EV_FRAME;
          res_len_next   = crc_len;
          res_offs_next  = 2'd2;
        end else begin
          res_event_next = EV_CRC_BAD;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      idle_cd      <= '0;
      pulse_cd     <= '0;
      out_valid    <= 1'b0;
      line_mode    <= 1'b1;
      crc_enable   <= 1'b0;
      idle_ticks   <= 16'd10;
      buffer_limit <= 8'd255;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      idle_cd   <= idle_cd_next;
      pulse_cd  <= pulse_cd_next;
      out_valid <= out_valid_next;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_LINE_MODE:    line_mode    <= cfg_ch.data[0];
          REG_CRC_ENABLE:   crc_enable   <= cfg_ch.data[0];
          REG_IDLE_TICKS:   idle_ticks   <= cfg_ch.data;
          REG_BUFFER_LIMIT: buffer_limit <= cfg_ch.data[BYTE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    last_byte <= last_byte_next;
    crc_len   <= crc_len_next;
    walk_idx  <= walk_idx_next;
    got       <= got_next;
    prod      <= prod_next;
    res_event <= res_event_next;
    res_len   <= res_len_next;
    res_offs  <= res_offs_next;
    res_rdata <= res_rdata_next;
    if (out_load) begin
      out_ch.event_res      <= res_event;
      out_ch.frame_length   <= res_len;
      out_ch.payload_offset <= res_offs;
      out_ch.read_data      <= res_rdata;
      out_ch.tx_low         <= (pulse_cd != '0);
    end
  end

endmodule

// ===== dv/uart_line_frame_receiver_core_tb.sv =====
// Self-checking testbench for the UART line frame receiver core.
`timescale 1ns / 100ps

module uart_line_frame_receiver_core_tb;
  import ulfr_pkg::*;

  localparam int STORE_DEPTH  = 256;
  // The slowest correct stretch without any transaction is a receiver hold-off of
  // HOLD_CYCLES or the walk of a full CRC frame, both far below this limit.
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUEUE_DEPTH  = 32;
  localparam int REPORT_LINES = 40;

  // One input transaction and one result transaction, at the widths of the ports.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [BYTE_W-1:0]  rx_byte;
    logic [PULSE_W-1:0] pulse_us;
    logic [BYTE_W-1:0]  read_index;
  } rx_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  frame_length;
    logic [OFFS_W-1:0]  payload_offset;
    logic [BYTE_W-1:0]  read_data;
    logic               tx_low;
  } rx_event_t;

  logic clk;
  logic rst;

  ulfr_in_if  in_ch();
  ulfr_out_if out_ch();
  ulfr_cfg_if cfg_ch();

  uart_line_frame_receiver_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the receiver: frame store, counters and the four registers.
  // The written flags keep the stimulus from reading a store entry that was never filled.
  logic [BYTE_W-1:0]   rx_store [STORE_DEPTH];
  bit                  store_written [STORE_DEPTH];
  logic [BYTE_W-1:0]   fill_idx;
  logic [IDLE_W-1:0]   idle_left;
  logic [PCOUNT_W-1:0] pulse_left;
  logic                cfg_line_mode;
  logic                cfg_crc_en;
  logic [IDLE_W-1:0]   cfg_idle_ticks;
  logic [BYTE_W-1:0]   cfg_buf_limit;

  rx_item_t  pending_items [$];
  rx_event_t expected_events [$];

  rx_item_t  next_item;
  rx_item_t  taken_item;
  rx_event_t seen_event;
  bit        in_fired;
  bit        steady_flow;
  int        send_gap;
  int        stall_left;
  int        hold_left;
  int        holds_done;
  int        quiet_cycles;
  int        items_queued;
  int        items_accepted;
  int        events_checked;
  int        error_count;
  int        settings_used;
  int        frames_seen;
  int        crc_drops_seen;
  int        flushes_seen;
  int        reads_seen;
  int        silent_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One byte of CRC16-CCITT, MSB first, no reflection.
  function automatic logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // The fill index wraps to zero once it has reached the buffer limit.
  function automatic logic [BYTE_W-1:0] next_fill(logic [BYTE_W-1:0] f);
    return (f < cfg_buf_limit) ? f + 8'd1 : 8'd0;
  endfunction

  // Applies one accepted input transaction to the shadow state and returns the result
  // that the receiver has to produce for it.
  function automatic rx_event_t predict_event(rx_item_t it);
    rx_event_t        res;
    int unsigned      frame_bytes;
    logic [CRC_W-1:0] crc_calc;
    res = '0;
    frame_bytes = 0;
    case (it.command)
      CMD_BYTE: begin
        rx_store[fill_idx] = it.rx_byte;
        store_written[fill_idx] = 1'b1;
        if (cfg_line_mode) begin
          // A frame ends on LF only when the byte just below the fill index is CR.
          if (fill_idx != 0 && rx_store[fill_idx - 8'd1] == CH_CR && it.rx_byte == CH_LF) begin
            frame_bytes = fill_idx + 1;
            fill_idx = '0;
          end else begin
            fill_idx = next_fill(fill_idx);
          end
          if (cfg_crc_en) begin
            // Frames too short to hold CRC, CR and LF are dropped without an event.
            if (frame_bytes >= MIN_WITH_CRC) begin
              crc_calc = CRC_INIT;
              for (int i = 0; i < frame_bytes - MIN_WITH_CRC; i++)
                crc_calc = crc16_step(crc_calc, rx_store[8'(i + 2)]);
              if ({rx_store[0], rx_store[1]} == crc_calc) begin
                res.event_res      = EV_FRAME;
                res.frame_length   = 8'(frame_bytes - MIN_WITH_CRC);
                res.payload_offset = 2'd2;
              end else begin
                res.event_res = EV_CRC_BAD;
              end
            end
          end else if (frame_bytes >= MIN_PLAIN) begin
            res.event_res    = EV_FRAME;
            res.frame_length = 8'(frame_bytes - MIN_PLAIN);
          end
        end else begin
          idle_left = cfg_idle_ticks;
          fill_idx = next_fill(fill_idx);
        end
      end
      CMD_TICK: begin
        // Raw mode: silence counts down, then the buffered bytes are flushed.
        if (!cfg_line_mode && fill_idx != 0) begin
          if (idle_left != 0) begin
            idle_left = idle_left - 1'b1;
          end else begin
            res.event_res    = EV_FLUSH;
            res.frame_length = fill_idx;
            fill_idx = '0;
          end
        end
        // The end of a low pulse clears the buffer, even on the same tick as a flush.
        if (pulse_left != 0) begin
          pulse_left = pulse_left - 1'b1;
          if (pulse_left == 0) fill_idx = '0;
        end
      end
      CMD_PULSE: begin
        pulse_left = PCOUNT_W'(1 + it.pulse_us / 5);
      end
      CMD_READ: begin
        res.event_res = EV_READ;
        res.read_data = rx_store[it.read_index];
      end
      default: ;
    endcase
    res.tx_low = (pulse_left != 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= REPORT_LINES)
      $display("[%0t] MISMATCH %s after %0d results: got %0h, expected %0h",
               $time, what, events_checked, got, want);
  endtask

  task automatic check_event(rx_event_t got);
    rx_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(got), 32'd0);
      return;
    end
    want = expected_events.pop_front();
    events_checked++;
    if (got.event_res !== want.event_res)
      report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
    if (got.frame_length !== want.frame_length)
      report_mismatch("frame_length", 32'(got.frame_length), 32'(want.frame_length));
    if (got.payload_offset !== want.payload_offset)
      report_mismatch("payload_offset", 32'(got.payload_offset), 32'(want.payload_offset));
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
    if (got.tx_low !== want.tx_low)
      report_mismatch("tx_low", 32'(got.tx_low), 32'(want.tx_low));
    case (want.event_res)
      EV_FRAME:   frames_seen++;
      EV_CRC_BAD: crc_drops_seen++;
      EV_FLUSH:   flushes_seen++;
      EV_READ:    reads_seen++;
      default:    silent_seen++;
    endcase
  endtask

  // Everything is sampled at the rising edge. The result is checked before the input
  // transaction of the same edge is predicted, so a result can never be matched against
  // an item that the block has only just taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        seen_event = '{event_res: out_ch.event_res, frame_length: out_ch.frame_length,
                       payload_offset: out_ch.payload_offset, read_data: out_ch.read_data,
                       tx_low: out_ch.tx_low};
        check_event(seen_event);
      end
      if (in_ch.valid && in_ch.ready) begin
        taken_item = '{command: in_ch.command, rx_byte: in_ch.rx_byte,
                       pulse_us: in_ch.pulse_us, read_index: in_ch.read_index};
        expected_events.push_back(predict_event(taken_item));
        in_fired = 1'b1;
        items_accepted++;
      end
      // Watchdog: any transaction on any channel counts as progress.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] No transaction for %0d cycles, %0d results still pending",
                 $time, quiet_cycles, expected_events.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving: everything changes at the falling edge
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one; none at all while steady_flow is set.
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender: holds an offered item until it is taken, then waits out its gap and offers
  // the next one from the pending queue.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      in_fired = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_ch.command    <= next_item.command;
        in_ch.rx_byte    <= next_item.rx_byte;
        in_ch.pulse_us   <= next_item.pulse_us;
        in_ch.read_index <= next_item.read_index;
        in_ch.valid      <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs during which the sender keeps
  // offering, so the block fills up and has to push back on its input.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (holds_done < 2 && events_checked >= 300 + 600 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fields that the command does not use still carry random values.
  function automatic rx_item_t noise_item(logic [CMD_W-1:0] cmd);
    rx_item_t it;
    it.command    = cmd;
    it.rx_byte    = BYTE_W'($urandom);
    it.pulse_us   = PULSE_W'($urandom);
    it.read_index = BYTE_W'($urandom);
    return it;
  endfunction

  task automatic push_item(rx_item_t it);
    while (pending_items.size() >= QUEUE_DEPTH) @(posedge clk);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_byte(logic [BYTE_W-1:0] data);
    rx_item_t it;
    it = noise_item(CMD_BYTE);
    it.rx_byte = data;
    push_item(it);
  endtask

  task automatic push_tick();
    push_item(noise_item(CMD_TICK));
  endtask

  task automatic push_pulse(logic [PULSE_W-1:0] us);
    rx_item_t it;
    it = noise_item(CMD_PULSE);
    it.pulse_us = us;
    push_item(it);
  endtask

  // Waits until every queued item has been taken by the block and predicted.
  task automatic settle_input();
    while (pending_items.size() != 0 || in_ch.valid) @(posedge clk);
  endtask

  task automatic wait_drain();
    settle_input();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_written();
    int idx;
    repeat (64) begin
      idx = $urandom_range(0, STORE_DEPTH - 1);
      if (store_written[idx]) return idx;
    end
    for (int i = 0; i < STORE_DEPTH; i++) if (store_written[i]) return i;
    return -1;
  endfunction

  // Store entries never lose their written flag, so an entry already written when the
  // read is queued is still written when the block takes the read.
  task automatic push_read(int want);
    int       idx;
    rx_item_t it;
    if (want >= 0 && !store_written[want]) settle_input();
    idx = (want >= 0 && store_written[want]) ? want : pick_written();
    if (idx < 0) begin
      push_tick();
      return;
    end
    it = noise_item(CMD_READ);
    it.read_index = BYTE_W'(idx);
    push_item(it);
  endtask

  // A line frame: optional CRC of the payload (high byte first), payload, CR, LF.
  task automatic push_frame(int len, bit spoil);
    logic [BYTE_W-1:0] body [$];
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  crc;
    crc = CRC_INIT;
    repeat (len) begin
      b = BYTE_W'($urandom);
      body.push_back(b);
      crc = crc16_step(crc, b);
    end
    if (cfg_crc_en) begin
      if (spoil) crc = crc ^ (16'd1 << $urandom_range(0, CRC_W - 1));
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
    end
    foreach (body[i]) push_byte(body[i]);
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  function automatic int frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(0, 12);
    if (r < 99) return $urandom_range(13, 40);
    return $urandom_range(41, 250);
  endfunction

  // Mostly pulses of a few ticks, sometimes one of the full 20-bit range.
  function automatic logic [PULSE_W-1:0] pulse_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return PULSE_W'($urandom_range(0, 40));
    if (r < 95) return PULSE_W'($urandom_range(41, 300));
    return PULSE_W'($urandom);
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_LINE_MODE:    cfg_line_mode  = value[0];
      REG_CRC_ENABLE:   cfg_crc_en     = value[0];
      REG_IDLE_TICKS:   cfg_idle_ticks = value[IDLE_W-1:0];
      REG_BUFFER_LIMIT: cfg_buf_limit  = value[BYTE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers change only once the block has delivered every pending result.
  task automatic set_config(bit line, bit crc, int idle, int limit);
    wait_drain();
    write_reg(REG_LINE_MODE, CFG_W'(line));
    write_reg(REG_CRC_ENABLE, CFG_W'(crc));
    write_reg(REG_IDLE_TICKS, CFG_W'(idle));
    write_reg(REG_BUFFER_LIMIT, CFG_W'(limit));
    settings_used++;
  endtask

  // Random traffic under the current setting. In line mode most of it is whole frames
  // with random payloads; the rest is broken frames, stray bytes, ticks, pulses and reads.
  task automatic random_mix(int count);
    int target;
    int r;
    int n;
    target = items_queued + count;
    while (items_queued < target) begin
      r = $urandom_range(0, 99);
      if (cfg_line_mode) begin
        if (r < 55) begin
          push_frame(frame_len(), $urandom_range(0, 9) == 0);
        end else if (r < 65) begin
          repeat ($urandom_range(1, 5)) push_byte(BYTE_W'($urandom));
          if ($urandom_range(0, 1)) begin
            push_byte(CH_CR);
            push_byte(8'h20);
          end
        end else if (r < 77) begin
          push_tick();
        end else if (r < 83) begin
          push_pulse(pulse_len());
        end else if (r < 95) begin
          push_read(-1);
        end else begin
          push_byte(BYTE_W'($urandom));
        end
      end else begin
        if (r < 45) begin
          repeat ($urandom_range(1, 8)) push_byte(BYTE_W'($urandom));
        end else if (r < 75) begin
          n = (cfg_idle_ticks <= 6) ? $urandom_range(1, cfg_idle_ticks + 2) : $urandom_range(1, 4);
          repeat (n) push_tick();
        end else if (r < 83) begin
          push_pulse(pulse_len());
        end else begin
          push_read(-1);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_BYTE;
    in_ch.rx_byte    = '0;
    in_ch.pulse_us   = '0;
    in_ch.read_index = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_LINE_MODE;
    cfg_ch.data      = '0;

    // Register defaults and cleared counters, as after reset.
    fill_idx       = '0;
    idle_left      = '0;
    pulse_left     = '0;
    cfg_line_mode  = 1'b1;
    cfg_crc_en     = 1'b0;
    cfg_idle_ticks = 16'd10;
    cfg_buf_limit  = 8'd255;
    settings_used  = 1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default setting: a one-byte frame, an empty frame, then an LF with no CR before it,
    // which must not end anything.
    push_byte(8'h41);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(CH_CR);
    push_byte(CH_LF);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CH_LF);
    push_read(0);
    push_read(2);
    // Shortest pulse ends on the next tick; a long pulse is cut short by a new one.
    push_pulse('0);
    push_tick();
    push_pulse('1);
    push_pulse(20'd7);
    push_tick();
    push_tick();

    // Walk the fill index over the whole store so that reads can reach every entry.
    repeat (STORE_DEPTH) push_byte(8'h80 | 8'($urandom_range(0, 9)));
    push_read(STORE_DEPTH - 1);
    push_read(128);
    random_mix(140);

    // CRC frames: a good one, one with a bad CRC, and one too short to hold a CRC.
    // The pulse first clears whatever the random part left in the buffer.
    set_config(1'b1, 1'b1, 10, 255);
    push_pulse('0);
    push_tick();
    push_frame(1, 1'b0);
    push_frame(0, 1'b1);
    push_byte(CH_CR);
    push_byte(CH_LF);
    random_mix(150);

    // Raw mode with no idle delay: flush on the first tick, a tick on an empty buffer,
    // and a flush that falls on the same tick as the end of a pulse.
    set_config(1'b0, 1'b0, 0, 255);
    push_byte(8'h5A);
    push_tick();
    push_tick();
    push_byte(8'hA5);
    push_pulse('0);
    push_tick();
    random_mix(140);

    steady_flow = 1'b1;
    set_config(1'b0, 1'b1, 3, 40);
    random_mix(130);
    steady_flow = 1'b0;

    // Buffer limit of 1: the fill index toggles between 0 and 1.
    set_config(1'b1, 1'b1, 65535, 1);
    random_mix(90);

    set_config(1'b1, 1'b0, 2, 12);
    random_mix(130);

    set_config(1'b0, 1'b0, 65535, 200);
    random_mix(90);

    set_config(1'b1, 1'b1, 1, 255);
    random_mix(80);
    steady_flow = 1'b1;
    random_mix(80);
    steady_flow = 1'b0;

    wait_drain();
    repeat (20) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch("results never delivered", expected_events.size(), 0);

    $display("Run covered %0d input transactions over %0d register settings; %0d results checked.",
             items_accepted, settings_used, events_checked);
    $display("Results: %0d frames, %0d CRC drops, %0d raw flushes, %0d reads, %0d silent; %0d errors.",
             frames_seen, crc_drops_seen, flushes_seen, reads_seen, silent_seen, error_count);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
